>>> hw/rtl/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

    // Heap geometry
    localparam int HEAP_BYTES   = 1024;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BITS   = $clog2(ALIGN_BYTES);
    localparam int GRANULES     = HEAP_BYTES / ALIGN_BYTES;
    localparam int HDR_SPAN     = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int TOTAL_BYTES  = GRANULES * ALIGN_BYTES;
    localparam int INIT_PAYLOAD = (TOTAL_BYTES > HDR_SPAN) ? TOTAL_BYTES - HDR_SPAN : 0;

    // Field widths
    localparam int GRAN_W  = $clog2(GRANULES);
    localparam int SIZE_W  = 11;
    localparam int REQ_W   = 16;
    localparam int RSIZE_W = REQ_W + 1;
    localparam int OFF_W   = 10;
    localparam int ST_W    = 2;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO     = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd3;

    typedef logic [GRAN_W-1:0] t_gidx;

    // One granule entry of the block table
    typedef struct packed {
        logic              starts;
        logic              is_free;
        logic [SIZE_W-1:0] size;
    } t_blk;

    typedef struct packed {
        logic  en;
        t_gidx addr;
        t_blk  data;
    } t_mem_wr;

    localparam t_blk INIT_BLK = '{starts: 1'b1, is_free: 1'b1, size: SIZE_W'(INIT_PAYLOAD)};

endpackage

`default_nettype wire

>>> hw/rtl/ffha_req_if.sv
`default_nettype none

interface ffha_req_if;
    import ffha_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] payload_offset;

    modport source (output valid, operation, request_size, payload_offset, input ready);
    modport sink   (input valid, operation, request_size, payload_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ffha_rsp_if.sv
`default_nettype none

interface ffha_rsp_if;
    import ffha_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] granted_offset;

    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ffha_mem.sv
`default_nettype none

module ffha_mem (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ffha_pkg::t_gidx  i_rd_addr,
    output ffha_pkg::t_blk        o_rd_data,
    input  wire ffha_pkg::t_mem_wr i_wr
);
    import ffha_pkg::*;

    t_blk                r_mem [GRANULES];
    logic [GRANULES-1:0] r_valid;
    t_blk                r_rd_data;
    logic                r_rd_valid;
    logic                r_rd_zero;

    // Entry valid bits: a never-written entry reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
        r_rd_zero  <= (i_rd_addr == '0);
    end

    always_comb begin
        if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else if (r_rd_zero) begin
            o_rd_data = INIT_BLK;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/first_fit_heap_allocator_unit.sv
// Channel  Dir  Payload                                   Handshake
// i_req    in   operation, request_size, payload_offset   valid / ready
// o_rsp    out  status, granted_offset                    valid / ready
//
// Steps: a free passes S_FCHK then S_DONE, or goes straight to S_DONE when its address
// is rejected at once; an allocate walks the blocks in S_WALK at one table read each
// (at most 32: a block spans 4+ granules), then passes S_SPLIT for a split, and S_DONE.
// Reset: synchronous, active low; the table returns to one free block at once.
// Stalls: a result waits in the output register while the next request
// transfers in; only that request's completion waits for o_rsp.ready.
`default_nettype none

module first_fit_heap_allocator_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);
    import ffha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_FCHK  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         r_state, n_state;
    t_gidx              r_g, n_g;
    logic [RSIZE_W-1:0] r_size, n_size;
    t_gidx              r_split_g, n_split_g;
    logic [SIZE_W-1:0]  r_rest, n_rest;
    logic [ST_W-1:0]    r_st, n_st;
    logic [OFF_W-1:0]   r_gr, n_gr;
    logic               r_out_valid, n_out_valid;
    logic [ST_W-1:0]    r_out_st, n_out_st;
    logic [OFF_W-1:0]   r_out_gr, n_out_gr;

    t_gidx   rd_addr;
    t_blk    blk;
    t_mem_wr wr;

    // Request decode
    logic [RSIZE_W-1:0] req_round;
    logic [OFF_W-1:0]   off_rel;
    logic               free_bad;

    // Walk arithmetic
    logic               fits;
    logic [SIZE_W-1:0]  rest;
    logic [SIZE_W:0]    hdr_plus_cur;
    logic [SIZE_W:0]    nxt;
    logic [RSIZE_W:0]   hdr_plus_req;
    logic [RSIZE_W:0]   split_idx;
    logic               do_split;
    logic [OFF_W:0]     grant_sum;

    ffha_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (blk),
        .i_wr      (wr)
    );

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_st;
    assign o_rsp.granted_offset = r_out_gr;

    always_comb begin
        // Round the request up to the alignment
        req_round = ({1'b0, i_req.request_size} + RSIZE_W'(ALIGN_BYTES - 1))
                    >> ALIGN_BITS << ALIGN_BITS;
        off_rel   = i_req.payload_offset - OFF_W'(HDR_SPAN);
        free_bad  = (i_req.payload_offset < OFF_W'(HDR_SPAN))
                 || (off_rel[ALIGN_BITS-1:0] != '0)
                 || ({1'b0, off_rel[OFF_W-1:ALIGN_BITS]} >= (OFF_W-ALIGN_BITS+1)'(GRANULES));

        // Block under inspection: fit test, leftover, next block, split point
        fits         = ({{(RSIZE_W-SIZE_W){1'b0}}, blk.size} >= r_size);
        rest         = blk.size - r_size[SIZE_W-1:0];
        hdr_plus_cur = (SIZE_W+1)'(HDR_SPAN) + {1'b0, blk.size};
        nxt          = (SIZE_W+1)'(r_g) + (hdr_plus_cur >> ALIGN_BITS);
        hdr_plus_req = (RSIZE_W+1)'(HDR_SPAN) + {1'b0, r_size};
        split_idx    = (RSIZE_W+1)'(r_g) + (hdr_plus_req >> ALIGN_BITS);
        do_split     = (rest > SIZE_W'(HDR_SPAN)) && (split_idx < (RSIZE_W+1)'(GRANULES));
        grant_sum    = {1'b0, r_g, {ALIGN_BITS{1'b0}}} + (OFF_W+1)'(HDR_SPAN);

        n_state     = r_state;
        n_g         = r_g;
        n_size      = r_size;
        n_split_g   = r_split_g;
        n_rest      = r_rest;
        n_st        = r_st;
        n_gr        = r_gr;
        n_out_valid = r_out_valid;
        n_out_st    = r_out_st;
        n_out_gr    = r_out_gr;
        rd_addr     = r_g;
        wr          = '0;

        // Drop the held result once it transfers
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_gr = '0;
                    if (i_req.operation == OP_ALLOC) begin
                        n_size = req_round;
                        if (i_req.request_size == '0) begin
                            n_st    = ST_ZERO;
                            n_state = S_DONE;
                        end else begin
                            // Start the walk at granule zero
                            n_g     = '0;
                            rd_addr = '0;
                            n_state = S_WALK;
                        end
                    end else begin
                        if (free_bad) begin
                            n_st    = ST_BAD_FREE;
                            n_state = S_DONE;
                        end else begin
                            n_g     = off_rel[ALIGN_BITS +: GRAN_W];
                            rd_addr = off_rel[ALIGN_BITS +: GRAN_W];
                            n_state = S_FCHK;
                        end
                    end
                end
            end
            S_FCHK: begin
                if (blk.starts) begin
                    wr.en   = 1'b1;
                    wr.addr = r_g;
                    wr.data = '{starts: 1'b1, is_free: 1'b1, size: blk.size};
                    n_st    = ST_OK;
                end else begin
                    n_st    = ST_BAD_FREE;
                end
                n_state = S_DONE;
            end
            S_WALK: begin
                if (!blk.starts) begin
                    n_st    = ST_NO_FIT;
                    n_state = S_DONE;
                end else if (blk.is_free && fits) begin
                    wr.en   = 1'b1;
                    wr.addr = r_g;
                    n_st    = ST_OK;
                    n_gr    = grant_sum[OFF_W-1:0];
                    if (do_split) begin
                        wr.data   = '{starts: 1'b1, is_free: 1'b0,
                                      size: r_size[SIZE_W-1:0]};
                        n_split_g = split_idx[GRAN_W-1:0];
                        n_rest    = rest - SIZE_W'(HDR_SPAN);
                        n_state   = S_SPLIT;
                    end else begin
                        wr.data = '{starts: 1'b1, is_free: 1'b0, size: blk.size};
                        n_state = S_DONE;
                    end
                end else if (nxt >= (SIZE_W+1)'(GRANULES)) begin
                    n_st    = ST_NO_FIT;
                    n_state = S_DONE;
                end else begin
                    // Advance to the next block and read it right away
                    n_g     = nxt[GRAN_W-1:0];
                    rd_addr = nxt[GRAN_W-1:0];
                end
            end
            S_SPLIT: begin
                // Write the free remainder as a block of its own
                wr.en   = 1'b1;
                wr.addr = r_split_g;
                wr.data = '{starts: 1'b1, is_free: 1'b1, size: r_rest};
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_st;
                    n_out_gr    = r_gr;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g       <= n_g;
        r_size    <= n_size;
        r_split_g <= n_split_g;
        r_rest    <= n_rest;
        r_st      <= n_st;
        r_gr      <= n_gr;
        r_out_st  <= n_out_st;
        r_out_gr  <= n_out_gr;
    end

    // A failed result (any status but OK) never carries a granted offset
    a_gr_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.granted_offset == '0))
        else $error("granted offset nonzero on an error result");

    // Table writes only while an item is in work
    a_wr_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_FCHK || r_state == S_WALK || r_state == S_SPLIT))
        else $error("table write outside of an operation");

    // A split always follows the walk step that picked the block
    a_split_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> ($past(r_state) == S_WALK))
        else $error("split entered from the wrong state");

    // A transfer in closes the request side until the result is loaded
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while one is in work");

endmodule

`default_nettype wire
